/* sv/kst_pkg.sv */
// Shared types and constants for the keyed shared region table.
// Used by kst_ctrl, kst_datapath and keyed_shared_region_table; no dependencies.
package kst_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int COUNT_BITS_DEF = 8;

  localparam int KEY_W    = 32;
  localparam int MASK_W   = 8;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    CMD_CREATE     = 2'd0,
    CMD_ATTACH     = 2'd1,
    CMD_DETACH     = 2'd2,
    CMD_DETACH_ALL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RES_FAIL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic scan_issue;
    logic finish;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_addr;
    logic out_free;
  } ctl_sts_t;

endpackage

/* sv/keyed_shared_region_table.sv */
// Top level of the keyed shared region table.
// Depends on kst_pkg, kst_ctrl and kst_datapath.
//
// Usage:
//   Requests enter on the input channel (in_valid / in_ready) with command,
//   key, already_mapped, resource_ok and mapped_slots; every request yields
//   exactly one result transfer on the output channel (out_valid / out_ready)
//   carrying status, slot_index and freed_slots.
//   Commands: create (find key or claim lowest free slot), attach (count up
//   once per new mapping, saturating), detach by key, detach all in a mask.
// Timing:
//   One request at a time. Each request walks every slot through the key and
//   count stores, one slot per cycle, then drains the read stage and loads the
//   result register; the next request is taken on the cycle after the result
//   is loaded.
// Reset:
//   Synchronous, active high rst empties the table: all slots free, counts
//   read as zero for free slots; no output is pending.
// Stall:
//   The result sits in an output register; a new request is taken while it
//   waits. If a second result is ready before the first is taken, hold it
//   in the finishing step until out_ready frees the register.
module keyed_shared_region_table #(
  parameter int SLOTS      = kst_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = kst_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        command,
  input  logic signed [kst_pkg::KEY_W-1:0]  key,
  input  logic                              already_mapped,
  input  logic                              resource_ok,
  input  logic [kst_pkg::MASK_W-1:0]        mapped_slots,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kst_pkg::STATUS_W-1:0]      status,
  output logic [kst_pkg::SLOT_W-1:0]        slot_index,
  output logic [kst_pkg::MASK_W-1:0]        freed_slots
);

  kst_pkg::ctl_cmd_t ctl_cmd;
  kst_pkg::ctl_sts_t ctl_sts;

  // Sequencer: accept, walk the slots, drain the read stage, finish.
  kst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // Slot stores, key compare, count update and result register.
  kst_datapath #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctl_cmd),
    .sts            (ctl_sts),
    .command        (command),
    .key            (key),
    .already_mapped (already_mapped),
    .resource_ok    (resource_ok),
    .mapped_slots   (mapped_slots),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .slot_index     (slot_index),
    .freed_slots    (freed_slots)
  );

endmodule

/* sv/kst_ctrl.sv */
// Sequencer for the keyed shared region table: accept, slot walk, drain, finish.
// Depends on kst_pkg.
module kst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kst_pkg::ctl_sts_t   sts,
  output kst_pkg::ctl_cmd_t   cmd
);

  kst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kst_pkg::S_IDLE: begin
        if (in_valid) state_next = kst_pkg::S_SCAN;
      end
      kst_pkg::S_SCAN: begin
        if (sts.last_addr) state_next = kst_pkg::S_DRAIN;
      end
      kst_pkg::S_DRAIN: begin
        state_next = kst_pkg::S_FINISH;
      end
      kst_pkg::S_FINISH: begin
        if (sts.out_free) state_next = kst_pkg::S_IDLE;
      end
      default: begin
        state_next = kst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.start      = 1'b0;
    cmd.scan_issue = 1'b0;
    cmd.finish     = 1'b0;
    case (state)
      kst_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      kst_pkg::S_SCAN: begin
        cmd.scan_issue = 1'b1;
      end
      kst_pkg::S_DRAIN: begin
      end
      kst_pkg::S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/kst_datapath.sv */
// Datapath of the keyed shared region table: request registers, slot stores,
// walk compare and count update, result register. Depends on kst_pkg.
module kst_datapath #(
  parameter int SLOTS      = kst_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = kst_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  kst_pkg::ctl_cmd_t            cmd,
  output kst_pkg::ctl_sts_t            sts,
  input  logic [1:0]                   command,
  input  logic signed [kst_pkg::KEY_W-1:0] key,
  input  logic                         already_mapped,
  input  logic                         resource_ok,
  input  logic [kst_pkg::MASK_W-1:0]   mapped_slots,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kst_pkg::STATUS_W-1:0] status,
  output logic [kst_pkg::SLOT_W-1:0]   slot_index,
  output logic [kst_pkg::MASK_W-1:0]   freed_slots
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EXT_W = IDX_W + kst_pkg::SLOT_W;

  // request
  kst_pkg::cmd_t               req_cmd;
  logic [kst_pkg::KEY_W-1:0]   req_key;
  logic                        req_mapped;
  logic                        req_ok;
  logic [kst_pkg::MASK_W-1:0]  req_mask;

  // slot stores
  logic [SLOTS-1:0]            used;
  logic [kst_pkg::KEY_W-1:0]   key_mem [SLOTS];
  logic [COUNT_BITS-1:0]       count_mem [SLOTS];
  logic [kst_pkg::KEY_W-1:0]   rd_key;
  logic [COUNT_BITS-1:0]       rd_cnt;

  // walk
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            cmp_idx;
  logic                        cmp_vld;
  logic                        found;
  logic [IDX_W-1:0]            match_idx;
  logic [COUNT_BITS-1:0]       match_cnt;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;
  logic [kst_pkg::MASK_W-1:0]  freed_acc;

  // combinational
  logic [COUNT_BITS-1:0]       eff_cnt;
  logic [COUNT_BITS-1:0]       all_dec;
  logic [EXT_W-1:0]            cmp_ext;
  logic                        in_mask;
  logic                        key_hit;
  logic                        all_hit;
  logic                        all_free;

  kst_pkg::status_t            fin_status;
  logic [IDX_W-1:0]            fin_slot;
  logic [kst_pkg::MASK_W-1:0]  fin_freed;
  logic                        fin_cnt_we;
  logic [COUNT_BITS-1:0]       fin_cnt_wd;
  logic                        fin_alloc;
  logic                        fin_release;
  logic [COUNT_BITS-1:0]       det_dec;
  logic [EXT_W-1:0]            match_ext;
  logic [EXT_W-1:0]            fin_ext;

  logic                        cnt_we;
  logic [IDX_W-1:0]            cnt_wa;
  logic [COUNT_BITS-1:0]       cnt_wd;

  assign sts.last_addr = (rd_addr == IDX_W'(SLOTS - 1));
  assign sts.out_free  = !out_valid || out_ready;

  // per-slot evaluation of the entry read last cycle
  always_comb begin
    eff_cnt  = used[cmp_idx] ? rd_cnt : '0;
    cmp_ext  = {{kst_pkg::SLOT_W{1'b0}}, cmp_idx};
    in_mask  = (cmp_ext < EXT_W'(kst_pkg::MASK_W)) && req_mask[cmp_ext[kst_pkg::SLOT_W-1:0]];
    key_hit  = used[cmp_idx] && (rd_key == req_key);
    all_hit  = cmp_vld && (req_cmd == kst_pkg::CMD_DETACH_ALL) && in_mask && used[cmp_idx];
    all_dec  = (eff_cnt != '0) ? eff_cnt - COUNT_BITS'(1) : '0;
    all_free = all_hit && (all_dec == '0);
  end

  // final decision once the walk is done
  always_comb begin
    fin_status  = kst_pkg::ST_OK;
    fin_slot    = '0;
    fin_freed   = '0;
    fin_cnt_we  = 1'b0;
    fin_cnt_wd  = '0;
    fin_alloc   = 1'b0;
    fin_release = 1'b0;
    det_dec     = (match_cnt != '0) ? match_cnt - COUNT_BITS'(1) : '0;
    match_ext   = {{kst_pkg::SLOT_W{1'b0}}, match_idx};
    case (req_cmd)
      kst_pkg::CMD_CREATE: begin
        if (found) begin
          fin_slot = match_idx;
        end else if (!free_found) begin
          fin_status = kst_pkg::ST_FULL;
        end else if (!req_ok) begin
          fin_status = kst_pkg::ST_RES_FAIL;
        end else begin
          fin_slot   = free_idx;
          fin_alloc  = 1'b1;
          fin_cnt_we = 1'b1;
        end
      end
      kst_pkg::CMD_ATTACH: begin
        if (!found) begin
          fin_status = kst_pkg::ST_NOT_FOUND;
        end else if (req_mapped) begin
          fin_slot = match_idx;
        end else if (!req_ok) begin
          fin_status = kst_pkg::ST_RES_FAIL;
        end else begin
          fin_slot   = match_idx;
          fin_cnt_we = 1'b1;
          fin_cnt_wd = (match_cnt != {COUNT_BITS{1'b1}}) ? match_cnt + COUNT_BITS'(1)
                                                          : match_cnt;
        end
      end
      kst_pkg::CMD_DETACH: begin
        if (!found) begin
          fin_status = kst_pkg::ST_NOT_FOUND;
        end else begin
          fin_slot = match_idx;
          if (req_mapped) begin
            fin_cnt_we = 1'b1;
            fin_cnt_wd = det_dec;
            if (det_dec == '0) begin
              fin_release = 1'b1;
              if (match_ext < EXT_W'(kst_pkg::MASK_W)) begin
                fin_freed[match_ext[kst_pkg::SLOT_W-1:0]] = 1'b1;
              end
            end
          end
        end
      end
      kst_pkg::CMD_DETACH_ALL: begin
        fin_freed = freed_acc;
      end
      default: begin
      end
    endcase
    fin_ext = {{kst_pkg::SLOT_W{1'b0}}, fin_slot};
  end

  // single count write port: walk write-back or final update
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = cmp_idx;
    cnt_wd = all_dec;
    if (cmd.finish) begin
      cnt_we = fin_cnt_we;
      cnt_wa = fin_alloc ? free_idx : match_idx;
      cnt_wd = fin_cnt_wd;
    end else if (all_hit) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_cnt <= count_mem[rd_addr];
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd.finish && fin_alloc) begin
      key_mem[free_idx] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_cmd    <= kst_pkg::cmd_t'(command);
      req_key    <= key;
      req_mapped <= already_mapped;
      req_ok     <= resource_ok;
      req_mask   <= mapped_slots;
    end
    if (cmd.scan_issue) begin
      cmp_idx <= rd_addr;
    end
    if (cmd.start) begin
      match_idx <= '0;
      match_cnt <= '0;
      free_idx  <= '0;
    end else if (cmp_vld) begin
      if (key_hit && !found) begin
        match_idx <= cmp_idx;
        match_cnt <= rd_cnt;
      end
      if (!used[cmp_idx] && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
    if (cmd.finish) begin
      status     <= fin_status;
      slot_index <= fin_ext[kst_pkg::SLOT_W-1:0];
      freed_slots <= fin_freed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      rd_addr    <= '0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      freed_acc  <= '0;
      out_valid  <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_issue;
      if (cmd.start) begin
        rd_addr    <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
        freed_acc  <= '0;
      end else begin
        if (cmd.scan_issue) begin
          rd_addr <= rd_addr + IDX_W'(1);
        end
        if (cmp_vld && key_hit) begin
          found <= 1'b1;
        end
        if (cmp_vld && !used[cmp_idx]) begin
          free_found <= 1'b1;
        end
        if (all_free) begin
          used[cmp_idx] <= 1'b0;
          freed_acc[cmp_ext[kst_pkg::SLOT_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (fin_alloc) begin
          used[free_idx] <= 1'b1;
        end
        if (fin_release) begin
          used[match_idx] <= 1'b0;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
